// ===== rtl/core/rtac_pkg.sv =====
// ----------------------------------------------------------------------------
// rtac_pkg : shared types and constants of the tag access controller
// Register indexes, event codes, door phases and reset values.
// ----------------------------------------------------------------------------
package rtac_pkg;

  localparam int unsigned MaxKeysDefault = 128;
  localparam int unsigned KeyW    = 32;
  localparam int unsigned SerialW = 40;
  localparam int unsigned TimeW   = 16;

  localparam logic [2:0] RegMasterTimeout = 3'd0;
  localparam logic [2:0] RegOpenTravel    = 3'd1;
  localparam logic [2:0] RegHoldOpen      = 3'd2;
  localparam logic [2:0] RegCloseTravel   = 3'd3;
  localparam logic [2:0] RegIdleReturn    = 3'd4;
  localparam logic [2:0] RegServoOpen     = 3'd5;
  localparam logic [2:0] RegServoClosed   = 3'd6;

  localparam logic [1:0] CmdTick  = 2'd0;
  localparam logic [1:0] CmdScan  = 2'd1;
  localparam logic [1:0] CmdClear = 2'd2;

  localparam logic [3:0] EvNone          = 4'd0;
  localparam logic [3:0] EvMasterSet     = 4'd1;
  localparam logic [3:0] EvMasterOn      = 4'd2;
  localparam logic [3:0] EvMasterOff     = 4'd3;
  localparam logic [3:0] EvAdded         = 4'd4;
  localparam logic [3:0] EvRemoved       = 4'd5;
  localparam logic [3:0] EvFull          = 4'd6;
  localparam logic [3:0] EvGranted       = 4'd7;
  localparam logic [3:0] EvDenied        = 4'd8;
  localparam logic [3:0] EvMasterTimeout = 4'd9;

  localparam logic [1:0] DoorClosed  = 2'd0;
  localparam logic [1:0] DoorOpening = 2'd1;
  localparam logic [1:0] DoorOpen    = 2'd2;
  localparam logic [1:0] DoorClosing = 2'd3;

  localparam logic [1:0] DevNone    = 2'd0;
  localparam logic [1:0] DevOpened  = 2'd1;
  localparam logic [1:0] DevClosing = 2'd2;
  localparam logic [1:0] DevClosed  = 2'd3;

  localparam logic [15:0] RstMasterTimeout = 16'd5000;
  localparam logic [15:0] RstOpenTravel    = 16'd3000;
  localparam logic [15:0] RstHoldOpen      = 16'd5000;
  localparam logic [15:0] RstCloseTravel   = 16'd3000;
  localparam logic [15:0] RstIdleReturn    = 16'd7000;
  localparam logic [15:0] RstServoOpen     = 16'd4799;
  localparam logic [15:0] RstServoClosed   = 16'd1499;

  // control sent from the sequencer into the key chain
  typedef struct packed {
    logic            load;    // start a search pass with the probe key
    logic            append;  // write the probe key at the tail
    logic            remove;  // overwrite the hit cell with the tail entry
  } rtac_chain_ctl_t;

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

endpackage

// ===== rtl/core/rtac_key_cell.sv =====
// ----------------------------------------------------------------------------
// rtac_key_cell : one slot of the key chain
// Holds one key, compares the probe travelling past and forwards it.
// ----------------------------------------------------------------------------
module rtac_key_cell (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    occupied_i,
  input  logic                    probe_vld_i,
  input  logic [rtac_pkg::KeyW-1:0] probe_i,
  input  logic                    wr_en_i,
  input  logic [rtac_pkg::KeyW-1:0] wr_key_i,
  output logic                    probe_vld_o,
  output logic [rtac_pkg::KeyW-1:0] probe_o,
  output logic                    hit_o,
  output logic [rtac_pkg::KeyW-1:0] key_o
);
  import rtac_pkg::*;

  logic [KeyW-1:0] key_q;
  logic [KeyW-1:0] probe_q;
  logic            vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      key_q <= wr_key_i;
    end
    probe_q <= probe_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= probe_vld_i;
    end
  end

  // the probe is compared in the cycle it sits at this cell
  assign hit_o       = probe_vld_i && occupied_i && (probe_i == key_q);
  assign probe_vld_o = vld_q;
  assign probe_o     = probe_q;
  assign key_o       = key_q;

endmodule

// ===== rtl/core/rtac_key_chain.sv =====
// ----------------------------------------------------------------------------
// rtac_key_chain : row of key cells
// A probe walks one cell a cycle; the first hit position is latched.
// ----------------------------------------------------------------------------
module rtac_key_chain #(
  parameter int unsigned MaxKeys = rtac_pkg::MaxKeysDefault,
  parameter int unsigned IdxW    = $clog2(MaxKeys + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  rtac_pkg::rtac_chain_ctl_t   ctl_i,
  input  logic [rtac_pkg::KeyW-1:0]   key_i,
  input  logic [IdxW-1:0]             total_i,
  output logic                        done_o,
  output logic                        found_o
);
  import rtac_pkg::*;

  localparam int unsigned PosW = (MaxKeys > 1) ? $clog2(MaxKeys) : 1;

  logic [MaxKeys:0]          vld_w;
  logic [KeyW-1:0]           probe_w [MaxKeys+1];
  logic [MaxKeys-1:0]        hit_w;
  logic [KeyW-1:0]           key_w   [MaxKeys];
  logic [IdxW-1:0]           step_q;
  logic                      busy_q;
  logic                      found_q;
  logic [IdxW-1:0]           pos_q;
  logic [KeyW-1:0]           tail_key;
  logic [IdxW-1:0]           tail_idx;

  assign vld_w[0]   = ctl_i.load;
  assign probe_w[0] = key_i;
  assign tail_idx   = total_i - IdxW'(1);

  always_comb begin
    tail_key = key_w[0];
    for (int i = 0; i < MaxKeys; i++) begin
      if (tail_idx == IdxW'(i)) begin
        tail_key = key_w[i];
      end
    end
  end

  for (genvar g = 0; g < MaxKeys; g++) begin : g_cell
    logic wr_en;
    logic [KeyW-1:0] wr_key;
    always_comb begin
      wr_en  = 1'b0;
      wr_key = key_i;
      if (ctl_i.append && total_i == IdxW'(g)) begin
        wr_en = 1'b1;
      end else if (ctl_i.remove && pos_q == IdxW'(g)) begin
        wr_en  = 1'b1;
        wr_key = tail_key;
      end
    end
    rtac_key_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .occupied_i  (IdxW'(g) < total_i),
      .probe_vld_i (vld_w[g]),
      .probe_i     (probe_w[g]),
      .wr_en_i     (wr_en),
      .wr_key_i    (wr_key),
      .probe_vld_o (vld_w[g+1]),
      .probe_o     (probe_w[g+1]),
      .hit_o       (hit_w[g]),
      .key_o       (key_w[g])
    );
  end

  // at most one hit per cycle since the probe occupies a single cell;
  // step_q names the cell the probe sits at
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      found_q <= 1'b0;
      pos_q   <= '0;
      step_q  <= '0;
    end else if (ctl_i.load) begin
      busy_q  <= (MaxKeys > 1);
      found_q <= hit_w[0];
      pos_q   <= '0;
      step_q  <= IdxW'(1);
    end else if (busy_q) begin
      if (hit_w[step_q[PosW-1:0]] && !found_q) begin
        found_q <= 1'b1;
        pos_q   <= step_q;
      end
      if (step_q == IdxW'(MaxKeys - 1)) begin
        busy_q <= 1'b0;
      end
      step_q <= step_q + IdxW'(1);
    end
  end

  assign done_o  = !busy_q && !ctl_i.load;
  assign found_o = found_q;

endmodule

// ===== rtl/core/rfid_tag_access_controller_top.sv =====
// ----------------------------------------------------------------------------
// rfid_tag_access_controller_top : tag access controller
//
//  channel | signals                          | accepted when
//  in      | in_valid_i/in_ready_o            | valid and ready high
//  out     | out_valid_o/out_ready_i          | valid and ready high
//  cfg     | cfg_we_i, cfg_idx_i, cfg_data_i  | cfg_we_i high
//
// Ticks, clears, repeated scans and master-key scans give their result in the
// cycle after the item is taken. A fresh scan that needs the key table walks
// the probe through the chain of MaxKeys cells in StLoad and StSearch; its
// result is registered when the walk ends. One item is in work at a time; a held
// result blocks the next item only until taken. Reset clears all control state.
// ----------------------------------------------------------------------------
module rfid_tag_access_controller_top #(
  parameter int unsigned MaxKeys = rtac_pkg::MaxKeysDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  command_i,
  input  logic [39:0] tag_serial_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  tag_event_o,
  output logic [1:0]  door_event_o,
  output logic        servo_valid_o,
  output logic [15:0] servo_position_o,
  output logic [1:0]  door_phase_o,
  output logic        in_master_mode_o,
  output logic        master_known_o,
  output logic [7:0]  key_count_o,
  output logic        idle_return_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);
  import rtac_pkg::*;

  localparam int unsigned IdxW = $clog2(MaxKeys + 1);

  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StLoad   = 2'd1;
  localparam logic [1:0] StSearch = 2'd2;

  logic [1:0]  state_q;
  logic [15:0] r_mto_q, r_open_q, r_hold_q, r_close_q, r_idle_q, r_spo_q, r_spc_q;
  logic [KeyW-1:0] master_key_q, key_q;
  logic        master_stored_q, master_active_q;
  logic [SerialW-1:0] prev_q;
  logic [15:0] master_el_q, door_el_q, idle_el_q;
  logic [1:0]  door_q;
  logic [IdxW-1:0] total_q;

  logic        ov_q;
  logic [3:0]  o_tev_q;
  logic [1:0]  o_dev_q;
  logic        o_sv_q;
  logic [15:0] o_sp_q;
  logic        o_idle_q;

  rtac_chain_ctl_t ctl;
  logic        ch_done, ch_found;

  logic        take, out_free;

  rtac_key_chain #(.MaxKeys(MaxKeys), .IdxW(IdxW)) u_chain (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl),
    .key_i   (key_q),
    .total_i (total_q),
    .done_o  (ch_done),
    .found_o (ch_found)
  );

  assign out_free   = !ov_q || out_ready_i;
  assign in_ready_o = (state_q == StIdle) && out_free;
  assign take       = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_mto_q <= RstMasterTimeout; r_open_q <= RstOpenTravel;
      r_hold_q <= RstHoldOpen;     r_close_q <= RstCloseTravel;
      r_idle_q <= RstIdleReturn;   r_spo_q <= RstServoOpen;
      r_spc_q <= RstServoClosed;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegMasterTimeout: r_mto_q   <= cfg_data_i;
        RegOpenTravel:    r_open_q  <= cfg_data_i;
        RegHoldOpen:      r_hold_q  <= cfg_data_i;
        RegCloseTravel:   r_close_q <= cfg_data_i;
        RegIdleReturn:    r_idle_q  <= cfg_data_i;
        RegServoOpen:     r_spo_q   <= cfg_data_i;
        RegServoClosed:   r_spc_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      key_q <= tag_serial_i[SerialW-1:8];
    end
  end

  // chain control: start pass in StLoad, write on finishing the pass in master mode
  always_comb begin
    ctl        = '0;
    ctl.load   = (state_q == StLoad);
    if (state_q == StSearch && ch_done && master_active_q) begin
      ctl.remove = ch_found;
      ctl.append = !ch_found && (total_q < IdxW'(MaxKeys));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      master_stored_q <= 1'b0; master_active_q <= 1'b0;
      prev_q <= '0; master_el_q <= '0; door_el_q <= '0; idle_el_q <= '0;
      door_q <= DoorClosed; total_q <= '0; ov_q <= 1'b0;
      master_key_q <= '0;
      o_tev_q <= EvNone; o_dev_q <= DevNone; o_sv_q <= 1'b0;
      o_sp_q <= '0; o_idle_q <= 1'b0;
    end else if (take) begin : take_item
      logic [3:0]  tev;
      logic [1:0]  dev;
      logic        sv;
      logic [15:0] sp;
      logic        idl;
      logic        res;
      tev = EvNone; dev = DevNone; sv = 1'b0; sp = '0; idl = 1'b0; res = 1'b1;
      priority case (command_i)
        CmdTick: begin : tick
          logic ma;
          logic [1:0] dn;
          logic idle_rst;
          ma = master_active_q;
          dn = door_q;
          idle_rst = 1'b0;
          if (master_active_q) begin
            if (master_el_q >= r_mto_q) begin
              ma = 1'b0;
              tev = EvMasterTimeout;
            end else begin
              master_el_q <= sat_inc(master_el_q);
            end
          end
          master_active_q <= ma;
          unique case (door_q)
            DoorOpening:
              if (door_el_q >= r_open_q) begin
                dn = DoorOpen; door_el_q <= '0; dev = DevOpened;
              end else door_el_q <= sat_inc(door_el_q);
            DoorOpen:
              if (door_el_q >= r_hold_q) begin
                dn = DoorClosing; door_el_q <= '0; dev = DevClosing;
                sv = 1'b1; sp = r_spc_q;
              end else door_el_q <= sat_inc(door_el_q);
            DoorClosing:
              if (door_el_q >= r_close_q) begin
                dn = DoorClosed; dev = DevClosed;
                idle_el_q <= '0; idle_rst = 1'b1;
              end else door_el_q <= sat_inc(door_el_q);
            default: ;
          endcase
          door_q <= dn;
          if (!idle_rst) begin
            if (master_stored_q && idle_el_q >= r_idle_q &&
                dn == DoorClosed && !ma) begin
              idl = 1'b1; idle_el_q <= '0;
            end else begin
              idle_el_q <= sat_inc(idle_el_q);
            end
          end
        end
        CmdScan: begin
          if (tag_serial_i != prev_q) begin
            prev_q <= tag_serial_i;
            idle_el_q <= '0;
            if (!master_stored_q) begin
              master_key_q <= tag_serial_i[SerialW-1:8];
              master_stored_q <= 1'b1;
              tev = EvMasterSet;
            end else if (tag_serial_i[SerialW-1:8] == master_key_q) begin
              master_active_q <= !master_active_q;
              tev = master_active_q ? EvMasterOff : EvMasterOn;
              if (!master_active_q) master_el_q <= '0;
            end else begin
              // hold the result back until the table walk ends
              res = 1'b0;
              state_q <= StLoad;
            end
          end
        end
        CmdClear: prev_q <= '0;
        default: ;
      endcase
      ov_q <= res;
      o_tev_q <= tev; o_dev_q <= dev; o_sv_q <= sv;
      o_sp_q <= sp; o_idle_q <= idl;
    end else if (state_q == StLoad) begin
      state_q <= StSearch;
    end else if (state_q == StSearch && ch_done && out_free) begin
      state_q <= StIdle;
      ov_q <= 1'b1;
      if (master_active_q) begin
        master_el_q <= '0;
        if (ch_found) begin
          total_q <= total_q - IdxW'(1);
          o_tev_q <= EvRemoved; master_active_q <= 1'b0;
        end else if (total_q < IdxW'(MaxKeys)) begin
          total_q <= total_q + IdxW'(1);
          o_tev_q <= EvAdded; master_active_q <= 1'b0;
        end else begin
          o_tev_q <= EvFull;
        end
      end else if (ch_found) begin
        o_tev_q <= EvGranted; o_sv_q <= 1'b1; o_sp_q <= r_spo_q;
        door_q <= DoorOpening; door_el_q <= '0;
      end else begin
        o_tev_q <= EvDenied;
      end
    end else if (ov_q && out_ready_i) begin
      ov_q <= 1'b0;
    end
  end

  assign out_valid_o      = ov_q;
  assign tag_event_o      = o_tev_q;
  assign door_event_o     = o_dev_q;
  assign servo_valid_o    = o_sv_q;
  assign servo_position_o = o_sp_q;
  assign door_phase_o     = door_q;
  assign in_master_mode_o = master_active_q;
  assign master_known_o   = master_stored_q;
  assign key_count_o      = 8'(total_q);
  assign idle_return_o    = o_idle_q;

endmodule

// ===== rtl/core/rtac_checker.sv =====
// ----------------------------------------------------------------------------
// rtac_checker : port checks for the tag access controller
// Watches the top-level ports only.
// ----------------------------------------------------------------------------
module rtac_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [3:0]  tag_event_o,
  input logic        servo_valid_o,
  input logic        master_known_o,
  input logic [7:0]  key_count_o
);
  import rtac_pkg::*;

  // a pending result holds steady while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(tag_event_o))
    else $error("result changed while stalled");

  // a result that is not taken keeps the input closed
  a_in_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input open while result stalled");

  // the master key, once stored, stays stored
  a_master_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    master_known_o |=> master_known_o)
    else $error("master key lost");

  // key count moves by at most one per step
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_count_o == $past(key_count_o) || key_count_o == $past(key_count_o) + 8'd1 ||
    key_count_o == $past(key_count_o) - 8'd1)
    else $error("key count jumped");

  // a grant always commands the servo
  a_grant_servo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && tag_event_o == EvGranted |-> servo_valid_o)
    else $error("grant without servo command");

endmodule

bind rfid_tag_access_controller_top rtac_checker u_rtac_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .tag_event_o    (tag_event_o),
  .servo_valid_o  (servo_valid_o),
  .master_known_o (master_known_o),
  .key_count_o    (key_count_o)
);
